@@ hw/rtl/bbs_pkg.sv @@
package bbs_pkg;

   localparam int WORD_BITS = 32;
   localparam int CNT_W     = 6;

   localparam logic [1:0] REG_MODULUS = 2'd0;
   localparam logic [1:0] REG_SEED    = 2'd1;
   localparam logic [1:0] REG_BITS    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RED,
      ST_SQR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic token;
      logic mbit;
   } cell_ctl_type;

endpackage

@@ hw/rtl/bbs_cell.sv @@
module bbs_cell #(
   parameter int MOD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bbs_pkg::cell_ctl_type ctl,
   input  logic [MOD_WIDTH-1:0]  acc_in,
   input  logic [MOD_WIDTH-1:0]  mcand,
   input  logic [MOD_WIDTH-1:0]  modulus,
   output logic                  token_out,
   output logic [MOD_WIDTH-1:0]  acc_out
);

   logic                 token_ff;
   logic [MOD_WIDTH-1:0] acc_ff, acc_in_n;
   logic [MOD_WIDTH:0]   dbl, dred, sum;

   // shift one multiplier bit in: acc = 2*acc + bit*mcand, both reduced by one subtract
   always_comb begin
      dbl  = {acc_in, 1'b0};
      dred = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      sum  = dred + {1'b0, mcand};
      if (ctl.mbit) begin
         acc_in_n = (sum >= {1'b0, modulus}) ? MOD_WIDTH'(sum - {1'b0, modulus})
                                             : MOD_WIDTH'(sum);
      end else begin
         acc_in_n = MOD_WIDTH'(dred);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
      end else begin
         token_ff <= ctl.token;
      end
      if (ctl.token) begin
         acc_ff <= acc_in_n;
      end
   end

   assign token_out = token_ff;
   assign acc_out   = acc_ff;

endmodule

@@ hw/rtl/bbs_bit_word_generator.sv @@
// Blum Blum Shub word generator. Each request beat yields one response word of
// bits_per_word bits (capped at 32), first squaring in the least significant bit.
// Every squaring runs as two passes through a row of MOD_WIDTH bit cells, one
// cell per multiplier bit from the top: a reduction of the state by the modulus,
// then the square. A pass carries a token from the launch register through the
// register of each cell in turn, so a word takes two passes per bit. One request
// is worked on at a time; a finished word waits in the output register while
// the next request is taken.
module bbs_bit_word_generator #(
   parameter int MOD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] reload, [7:1] zero
   input  logic        req_tlast,   // final_request
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] word_out
   output logic        rsp_tlast,   // last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = bbs_pkg::CNT_W;

   logic [MOD_WIDTH-1:0] modulus_ff, seed_ff;
   logic [CW-1:0]        bits_ff;
   logic [1:0]           csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_WIDTH'(209);
         seed_ff    <= MOD_WIDTH'(3);
         bits_ff    <= CW'(16);
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[1:0] == 2'd0)) begin
         unique case (csr_idx)
            bbs_pkg::REG_MODULUS: modulus_ff <= MOD_WIDTH'(csr_pwdata);
            bbs_pkg::REG_SEED:    seed_ff    <= MOD_WIDTH'(csr_pwdata);
            bbs_pkg::REG_BITS:    bits_ff    <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         bbs_pkg::REG_MODULUS: csr_prdata = 32'(modulus_ff);
         bbs_pkg::REG_SEED:    csr_prdata = 32'(seed_ff);
         bbs_pkg::REG_BITS:    csr_prdata = 32'(bits_ff);
         default:              csr_prdata = 32'd0;
      endcase
   end

   // cell row
   logic                 launch_ff, launch_in;
   logic [MOD_WIDTH-1:0] oper_ff, mcand_ff;
   logic [MOD_WIDTH:0]   tok;
   logic [MOD_WIDTH-1:0] acc [MOD_WIDTH+1];
   bbs_pkg::cell_ctl_type ctl [MOD_WIDTH];

   assign tok[0] = launch_ff;
   assign acc[0] = '0;

   for (genvar k = 0; k < MOD_WIDTH; k++) begin : g_cell
      assign ctl[k].token = tok[k];
      assign ctl[k].mbit  = oper_ff[MOD_WIDTH-1-k];
      bbs_cell #(.MOD_WIDTH(MOD_WIDTH)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[k]),
         .acc_in    (acc[k]),
         .mcand     (mcand_ff),
         .modulus   (modulus_ff),
         .token_out (tok[k+1]),
         .acc_out   (acc[k+1])
      );
   end

   // sequencer
   bbs_pkg::state_type   state_ff, state_in;
   logic                 seeded_ff, seeded_in;
   logic [MOD_WIDTH-1:0] res_ff, res_in, oper_in, mcand_in, row_res;
   logic [CW-1:0]        cnt_ff, cnt_in, bit_ff, bit_in;
   logic [31:0]          word_ff, word_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in, out_load;
   logic [31:0]          rsp_data_ff;
   logic                 rsp_last_ff;
   logic                 req_fire, row_done, deg_mod;

   assign req_fire = req_tvalid && req_tready;
   assign row_done = tok[MOD_WIDTH];
   assign deg_mod  = (modulus_ff < MOD_WIDTH'(2));
   assign row_res  = deg_mod ? '0 : acc[MOD_WIDTH];
   assign req_tready = (state_ff == bbs_pkg::ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      seeded_in = seeded_ff;
      res_in    = res_ff;
      oper_in   = oper_ff;
      mcand_in  = mcand_ff;
      cnt_in    = cnt_ff;
      bit_in    = bit_ff;
      word_in   = word_ff;
      last_in   = last_ff;
      launch_in = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         bbs_pkg::ST_IDLE: begin
            if (req_fire) begin
               seeded_in = 1'b1;
               if (req_tdata[0] || !seeded_ff) begin
                  res_in  = seed_ff;
                  oper_in = seed_ff;
               end else begin
                  oper_in = res_ff;
               end
               mcand_in = MOD_WIDTH'(1);
               cnt_in   = (bits_ff > CW'(bbs_pkg::WORD_BITS)) ? CW'(bbs_pkg::WORD_BITS)
                                                               : bits_ff;
               bit_in   = '0;
               word_in  = '0;
               last_in  = req_tlast;
               state_in = (cnt_in == '0) ? bbs_pkg::ST_DONE : bbs_pkg::ST_RED;
            end
         end
         bbs_pkg::ST_RED: begin
            if (row_done) begin
               oper_in  = row_res;
               mcand_in = row_res;
               state_in = bbs_pkg::ST_SQR;
            end
         end
         bbs_pkg::ST_SQR: begin
            if (row_done) begin
               res_in           = row_res;
               word_in          = word_ff;
               word_in[bit_ff[4:0]] = row_res[0];
               bit_in           = bit_ff + CW'(1);
               oper_in          = row_res;
               mcand_in         = MOD_WIDTH'(1);
               state_in = (bit_in == cnt_ff) ? bbs_pkg::ST_DONE : bbs_pkg::ST_RED;
            end
         end
         bbs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = bbs_pkg::ST_IDLE;
            end
         end
         default: state_in = bbs_pkg::ST_IDLE;
      endcase
      // start a pass on every entry into a row state, once operands are loaded
      if ((state_in == bbs_pkg::ST_RED || state_in == bbs_pkg::ST_SQR)
          && (state_in != state_ff)) begin
         launch_in = 1'b1;
      end
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbs_pkg::ST_IDLE;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         res_ff       <= '0;
         launch_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
         res_ff       <= res_in;
         launch_ff    <= launch_in;
      end
      oper_ff  <= oper_in;
      mcand_ff <= mcand_in;
      cnt_ff   <= cnt_in;
      bit_ff   <= bit_in;
      word_ff  <= word_in;
      last_ff  <= last_in;
      if (out_load) begin
         rsp_data_ff <= word_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_one_token: assert property (@(posedge clock) disable iff (reset) $onehot0(tok))
      else $error("more than one pass in the cell row");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken while a word is in work");
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bbs_pkg::ST_SQR) && !deg_mod |-> (mcand_ff < modulus_ff))
      else $error("square pass started on an unreduced state");
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bbs_pkg::ST_RED) |-> (bit_ff < cnt_ff))
      else $error("bit index beyond word length");

endmodule
